// ===== src/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg: shared types and constants of the LRU cache tag store
// Widths of the request, the result and the configuration registers, the
// layout of one set row in the tag memory, and a saturating increment function.
// ----------------------------------------------------------------------------
package slc_pkg;

	localparam int MAX_SET_BITS = 8;
	localparam int MAX_WAYS     = 8;
	localparam int MAX_BLOCK    = 32;

	localparam int ADDR_W  = 64;
	localparam int REQ_W   = 2;
	localparam int CNT_W   = 32;
	localparam int SET_W   = MAX_SET_BITS;
	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W  = WAY_W;
	// The smallest offset plus set index is two bits, so a tag never needs more.
	localparam int TAG_W   = ADDR_W - 2;

	// Configuration register widths
	localparam int SB_W    = 4;
	localparam int BB_W    = 6;
	localparam int WY_W    = 4;
	localparam int CFG_W   = 6;
	localparam int CFG_IDX_W = 2;
	localparam int SHIFT_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

	localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

	typedef struct packed {
		logic [MAX_WAYS-1:0]             vld;
		logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
		logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
	} set_row_t;

	localparam int ROW_W = $bits(set_row_t);

	typedef struct packed {
		logic hit;
		logic evicted;
	} lookup_res_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ===== src/slc_if.sv =====
// ----------------------------------------------------------------------------
// slc_if: request and result channels of the LRU cache tag store
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface slc_req_if import slc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [ADDR_W-1:0] address;

	modport source(output valid, req_type, address, input ready);
	modport sink(input valid, req_type, address, output ready);
endinterface

interface slc_rsp_if import slc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             hit;
	logic             evicted;
	logic             last;
	logic [CNT_W-1:0] hit_total;
	logic [CNT_W-1:0] miss_total;
	logic [CNT_W-1:0] evict_total;

	modport source(output valid, hit, evicted, last, hit_total, miss_total, evict_total,
		input ready);
	modport sink(input valid, hit, evicted, last, hit_total, miss_total, evict_total,
		output ready);
endinterface

// ===== src/slc_ram.sv =====
// ----------------------------------------------------------------------------
// slc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module slc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/slc_lookup.sv =====
// ----------------------------------------------------------------------------
// slc_lookup: tag compare and LRU update of one set row
// Finds a hit, a free way or the least recently used way, and builds the
// row that is written back.
// ----------------------------------------------------------------------------
module slc_lookup import slc_pkg::*; (
	input  set_row_t          row,
	input  logic [TAG_W-1:0]  tag,
	input  logic [WY_W-1:0]   ways,
	output set_row_t          row_new,
	output lookup_res_t       res
);

	logic [MAX_WAYS-1:0] way_en;
	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] free;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    free_way;
	logic [WAY_W-1:0]    lru_way;
	logic [RANK_W-1:0]   best;
	logic [WAY_W-1:0]    sel;
	logic [RANK_W-1:0]   old_rank;
	logic                hit;
	logic                found;
	logic                was_valid;

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			way_en[i] = WY_W'(i) < ways;
			match[i]  = way_en[i] && row.vld[i] && (row.tag[i] == tag);
			free[i]   = way_en[i] && !row.vld[i];
		end
		hit   = |match;
		found = |free;

		// Lowest-numbered way wins both searches.
		hit_way  = '0;
		free_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_way = WAY_W'(i);
			end
			if (free[i]) begin
				free_way = WAY_W'(i);
			end
		end

		best    = '0;
		lru_way = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (way_en[i] && row.rank[i] > best) begin
				best    = row.rank[i];
				lru_way = WAY_W'(i);
			end
		end

		sel       = hit ? hit_way : (found ? free_way : lru_way);
		was_valid = hit || !found;
		old_rank  = row.rank[sel];

		// Valid lines younger than the touched one age by one; a fill ages them all.
		row_new = row;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (way_en[i] && WAY_W'(i) != sel && row.vld[i] &&
					(!was_valid || row.rank[i] < old_rank) && row.rank[i] != RANK_MAX) begin
				row_new.rank[i] = row.rank[i] + RANK_W'(1);
			end
		end
		row_new.rank[sel] = '0;
		row_new.vld[sel]  = 1'b1;
		row_new.tag[sel]  = tag;

		res.hit     = hit;
		res.evicted = !hit && !found;
	end

endmodule

// ===== src/set_assoc_lru_cache_tags.sv =====
// Timing: a load or store word is accepted only in the idle state; its set row is
// read from the tag memory, then looked up, written back and its result put in
// the output register once that register is free; a modify gives a second result
// after the first. No new word is accepted until the last result is registered.
// Reset: all lines invalid at once through one valid flop per set (no clearing
// pass), totals zero, set_bits 4, block_bits 4, ways_in_use 1.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags: tag store of a set-associative LRU cache
// Looks up request addresses in a per-set tag row, fills or evicts on a miss
// and keeps saturating hit, miss and eviction totals.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags import slc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	slc_req_if.sink              req,
	slc_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	state_t state_q, state_d;

	logic [SB_W-1:0] set_bits_q;
	logic [BB_W-1:0] block_bits_q;
	logic [WY_W-1:0] ways_q;
	logic [SB_W-1:0] sb_c;
	logic [BB_W-1:0] bb_c;
	logic [WY_W-1:0] ways_c;

	logic [NUM_SETS-1:0] row_vld_q;
	logic                flush;

	logic [SET_W-1:0]   set_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic               modify_s1;
	logic               rvld_s1;
	logic               second_q;
	set_row_t           fwd_q;

	logic [ADDR_W-1:0]  set_full;
	logic [ADDR_W-1:0]  tag_full;
	logic [SET_W-1:0]   set_mask;
	logic [SET_W-1:0]   set_idx;
	logic [SHIFT_W-1:0] tag_shift;

	logic               accept;
	logic               rd_en;
	logic               can_push;
	logic               push;
	logic               push_last;
	logic [ROW_W-1:0]   rd_data;
	set_row_t           row_cur;
	set_row_t           row_new;
	lookup_res_t        res;

	logic [CNT_W-1:0]   hits_q;
	logic [CNT_W-1:0]   misses_q;
	logic [CNT_W-1:0]   evicts_q;
	logic [CNT_W-1:0]   hits_d;
	logic [CNT_W-1:0]   misses_d;
	logic [CNT_W-1:0]   evicts_d;

	logic               rsp_vld_q;
	logic               hit_q;
	logic               evicted_q;
	logic               last_q;

	// Configuration, clamped at use
	always_comb begin
		if (set_bits_q == '0) begin
			sb_c = SB_W'(1);
		end else if (set_bits_q > SB_W'(MAX_SET_BITS)) begin
			sb_c = SB_W'(MAX_SET_BITS);
		end else begin
			sb_c = set_bits_q;
		end
		if (block_bits_q == '0) begin
			bb_c = BB_W'(1);
		end else if (block_bits_q > BB_W'(MAX_BLOCK)) begin
			bb_c = BB_W'(MAX_BLOCK);
		end else begin
			bb_c = block_bits_q;
		end
		if (ways_q == '0) begin
			ways_c = WY_W'(1);
		end else if (ways_q > WY_W'(MAX_WAYS)) begin
			ways_c = WY_W'(MAX_WAYS);
		end else begin
			ways_c = ways_q;
		end
	end

	always_comb begin
		flush = 1'b0;
		unique case (cfg_index)
			CFG_SET_BITS, CFG_BLOCK_BITS, CFG_WAYS_IN_USE: flush = cfg_we;
			default: flush = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= SB_W'(4);
			block_bits_q <= BB_W'(4);
			ways_q       <= WY_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SET_BITS:    set_bits_q   <= cfg_data[SB_W-1:0];
				CFG_BLOCK_BITS:  block_bits_q <= cfg_data[BB_W-1:0];
				CFG_WAYS_IN_USE: ways_q       <= cfg_data[WY_W-1:0];
				default: ;
			endcase
		end
	end

	// Address split
	always_comb begin
		tag_shift = SHIFT_W'(bb_c) + SHIFT_W'(sb_c);
		set_full  = req.address >> bb_c;
		tag_full  = req.address >> tag_shift;
		set_mask  = ~({SET_W{1'b1}} << sb_c);
		set_idx   = set_full[SET_W-1:0] & set_mask;
	end

	// Control: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid && req.req_type != REQ_NONE) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (can_push && push_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control: outputs
	always_comb begin
		req.ready = 1'b0;
		push      = 1'b0;
		can_push  = !rsp_vld_q || rsp.ready;
		push_last = !(modify_s1 && !second_q);
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_LOOK: push      = can_push;
			default: ;
		endcase
		accept = req.valid && req.ready;
		rd_en  = accept && req.req_type != REQ_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				second_q <= 1'b0;
			end else if (push) begin
				second_q <= !push_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			set_s1    <= set_idx;
			tag_s1    <= tag_full[TAG_W-1:0];
			modify_s1 <= req.req_type == REQ_MODIFY;
			rvld_s1   <= row_vld_q[set_idx];
		end
		if (push) begin
			fwd_q <= row_new;
		end
	end

	// A set never written since the last flush reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (flush) begin
			row_vld_q <= '0;
		end else if (push) begin
			row_vld_q[set_s1] <= 1'b1;
		end
	end

	slc_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_SETS)
	) u_tag_ram (
		.clk  (clk),
		.we   (push),
		.waddr(set_s1),
		.wdata(row_new),
		.re   (rd_en),
		.raddr(set_idx),
		.rdata(rd_data)
	);

	// The second lookup of a modify sees the row the first one just wrote.
	always_comb begin
		if (second_q) begin
			row_cur = fwd_q;
		end else if (rvld_s1) begin
			row_cur = set_row_t'(rd_data);
		end else begin
			row_cur = '0;
		end
	end

	slc_lookup u_lookup (
		.row    (row_cur),
		.tag    (tag_s1),
		.ways   (ways_c),
		.row_new(row_new),
		.res    (res)
	);

	// Totals and output register
	always_comb begin
		hits_d   = res.hit ? sat_inc(hits_q) : hits_q;
		misses_d = res.hit ? misses_q : sat_inc(misses_q);
		evicts_d = res.evicted ? sat_inc(evicts_q) : evicts_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q    <= '0;
			misses_q  <= '0;
			evicts_q  <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (push) begin
				hits_q    <= hits_d;
				misses_q  <= misses_d;
				evicts_q  <= evicts_d;
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hit_q     <= res.hit;
			evicted_q <= res.evicted;
			last_q    <= push_last;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.hit         = hit_q;
	assign rsp.evicted     = evicted_q;
	assign rsp.last        = last_q;
	assign rsp.hit_total   = hits_q;
	assign rsp.miss_total  = misses_q;
	assign rsp.evict_total = evicts_q;

	// A result is never written over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!rsp_vld_q || rsp.ready))
		else $error("result register overwritten");

	// A lookup cannot both hit and evict.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !(res.hit && res.evicted))
		else $error("hit reported with eviction");

	// The first half of a modify is always followed by its second lookup.
	a_modify_second: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !push_last) |=> (state_q == ST_LOOK && second_q))
		else $error("modify lost its second lookup");

	// No more than one of the hit and miss totals moves per lookup (exactly one unless saturated).
	a_one_count: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> ((hits_q != $past(hits_q)) + (misses_q != $past(misses_q)) <= 1))
		else $error("hit and miss totals both advanced");

endmodule
